// ===== rtl/usgs_pkg.sv =====
// ============================================================================
// usgs_pkg
// Shared types and constants for the urgency gate signal statistics block.
// ============================================================================
package usgs_pkg;

  // Fixed-point formats: values are unsigned Q1.FRAC_BITS, boost is Q8.8.
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = CNT_W + 2;
  localparam int BOOST_W   = 16;
  localparam int BOOST_FRAC = 8;
  localparam int DIV_CNT_W = $clog2(VAL_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = VAL_W;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  // Register reset values.
  localparam logic [VAL_W-1:0]   THRESHOLD_RST = VAL_W'(13107);
  localparam logic [BOOST_W-1:0] BOOST_RST     = BOOST_W'(384);

  // Signal kinds.
  localparam logic [2:0] KIND_UPDATE      = 3'd0;
  localparam logic [2:0] KIND_PREDICTION  = 3'd1;
  localparam logic [2:0] KIND_CONFLICT    = 3'd2;
  localparam logic [2:0] KIND_INTEGRATION = 3'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATING_EN   = 3'd0,
    CFG_CONFLICT_EN = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_BOOST       = 3'd3,
    CFG_ATTENTION   = 3'd4
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ROUTED  = 2'd0,
    ST_GATED   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_BOOST,
    S_DECIDE,
    S_SETUP_C,
    S_DIV_C,
    S_FIX_C,
    S_SETUP_E,
    S_DIV_E,
    S_FIX_E,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic scale;
    logic boost;
    logic decide;
    logic setup_c;
    logic setup_e;
    logic div_step;
    logic fix_c;
    logic fix_e;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic routed;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/usgs_ctrl.sv =====
// ============================================================================
// usgs_ctrl
// Sequencer for one item: gate computation, counter update, two serial
// mean divisions and the hand-off to the output register.
// ============================================================================
module usgs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sig_valid,
  output logic             sig_stall,
  input  usgs_pkg::dp_stat_t stat,
  output usgs_pkg::cmd_t   cmd
);
  import usgs_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (sig_valid) state_next = S_SCALE;
      S_SCALE:   state_next = S_BOOST;
      S_BOOST:   state_next = S_DECIDE;
      S_DECIDE:  state_next = stat.routed ? S_SETUP_C : S_DONE;
      S_SETUP_C: state_next = S_DIV_C;
      S_DIV_C:   if (stat.div_done) state_next = S_FIX_C;
      S_FIX_C:   state_next = S_SETUP_E;
      S_SETUP_E: state_next = S_DIV_E;
      S_DIV_E:   if (stat.div_done) state_next = S_FIX_E;
      S_FIX_E:   state_next = S_DONE;
      S_DONE:    if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    sig_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        sig_stall   = 1'b0;
        cmd.load_in = sig_valid;
      end
      S_SCALE:   cmd.scale    = 1'b1;
      S_BOOST:   cmd.boost    = 1'b1;
      S_DECIDE:  cmd.decide   = 1'b1;
      S_SETUP_C: cmd.setup_c  = 1'b1;
      S_DIV_C:   cmd.div_step = 1'b1;
      S_FIX_C:   cmd.fix_c    = 1'b1;
      S_SETUP_E: cmd.setup_e  = 1'b1;
      S_DIV_E:   cmd.div_step = 1'b1;
      S_FIX_E:   cmd.fix_e    = 1'b1;
      S_DONE:    cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/usgs_datapath.sv =====
// ============================================================================
// usgs_datapath
// Configuration registers, urgency scaling, counters, running means with a
// shared restoring divider, and the output register.
// ============================================================================
module usgs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [usgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usgs_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic [2:0]                    kind,
  input  logic [usgs_pkg::VAL_W-1:0]    urgency,
  input  logic [usgs_pkg::VAL_W-1:0]    coherence,
  input  logic [usgs_pkg::VAL_W-1:0]    pred_error,
  input  usgs_pkg::cmd_t                cmd,
  output usgs_pkg::dp_stat_t            stat,
  input  logic                          res_stall,
  output logic                          res_valid,
  output logic [1:0]                    status,
  output logic [usgs_pkg::CNT_W-1:0]    update_count,
  output logic [usgs_pkg::CNT_W-1:0]    prediction_count,
  output logic [usgs_pkg::CNT_W-1:0]    conflict_count,
  output logic [usgs_pkg::CNT_W-1:0]    integration_count,
  output logic [usgs_pkg::CNT_W-1:0]    gated_count,
  output logic [usgs_pkg::VAL_W-1:0]    mean_coherence,
  output logic [usgs_pkg::VAL_W-1:0]    mean_pred_error
);
  import usgs_pkg::*;

  // Configuration registers.
  logic               gating_en;
  logic               conflict_en;
  logic [VAL_W-1:0]   threshold;
  logic [BOOST_W-1:0] boost;
  logic [VAL_W-1:0]   attention;

  // Captured item, values clamped to one on arrival.
  logic [2:0]         kind_r;
  logic [VAL_W-1:0]   urg_r;
  logic [VAL_W-1:0]   coh_r;
  logic [VAL_W-1:0]   perr_r;

  // Gate pipeline.
  logic [VAL_W-1:0]         eff1;
  logic [VAL_W-1:0]         eff;
  logic [VAL_W-1:0]         att_c;
  logic [2*VAL_W-1:0]       prod1;
  logic [VAL_W+BOOST_W-1:0] prod2;
  logic [VAL_W+BOOST_W-BOOST_FRAC-1:0] boosted;
  logic               gated;
  logic               routed;

  // Statistics.
  logic [CNT_W-1:0]   upd_cnt;
  logic [CNT_W-1:0]   pred_cnt;
  logic [CNT_W-1:0]   conf_cnt;
  logic [CNT_W-1:0]   integ_cnt;
  logic [CNT_W-1:0]   gate_cnt;
  logic [VAL_W-1:0]   coh_mean;
  logic [VAL_W-1:0]   err_mean;
  status_t            stat_code;

  // Divider.
  logic [TOT_W-1:0]     total;
  logic [VAL_W-1:0]     dvd;
  logic [VAL_W-1:0]     quo;
  logic [TOT_W-1:0]     rem;
  logic [TOT_W:0]       rem_sh;
  logic                 q_bit;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 x_ge_m;
  logic [VAL_W-1:0]     sel_mean;
  logic [VAL_W-1:0]     sel_x;
  logic [VAL_W-1:0]     fix_mean;
  logic [VAL_W-1:0]     fix_val;

  function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      gating_en   <= 1'b1;
      conflict_en <= 1'b1;
      threshold   <= THRESHOLD_RST;
      boost       <= BOOST_RST;
      attention   <= ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GATING_EN:   gating_en   <= cfg_data[0];
        CFG_CONFLICT_EN: conflict_en <= cfg_data[0];
        CFG_THRESHOLD:   threshold   <= cfg_data;
        CFG_BOOST:       boost       <= cfg_data[BOOST_W-1:0];
        CFG_ATTENTION:   attention   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      urg_r  <= clamp_one(urgency);
      coh_r  <= clamp_one(coherence);
      perr_r <= clamp_one(pred_error);
    end
  end

  // Urgency scaling by attention, then the conflict boost capped at one.
  assign att_c   = clamp_one(attention);
  assign prod1   = urg_r * att_c;
  assign prod2   = eff1 * boost;
  assign boosted = prod2[VAL_W+BOOST_W-1:BOOST_FRAC];

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      eff1 <= prod1[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end
    if (cmd.boost) begin
      if (conflict_en && kind_r == KIND_CONFLICT) begin
        eff <= (boosted > {{(BOOST_W-BOOST_FRAC){1'b0}}, ONE}) ? ONE : boosted[VAL_W-1:0];
      end else begin
        eff <= eff1;
      end
    end
  end

  // Gate decision.
  assign gated  = gating_en && (eff < threshold);
  assign routed = !gated && (kind_r <= KIND_INTEGRATION);

  // Counters and status code.
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_cnt   <= '0;
      pred_cnt  <= '0;
      conf_cnt  <= '0;
      integ_cnt <= '0;
      gate_cnt  <= '0;
    end else if (cmd.decide) begin
      if (gated) begin
        gate_cnt <= sat_inc(gate_cnt);
      end else if (routed) begin
        unique case (kind_r[1:0])
          KIND_UPDATE[1:0]:     upd_cnt   <= sat_inc(upd_cnt);
          KIND_PREDICTION[1:0]: pred_cnt  <= sat_inc(pred_cnt);
          KIND_CONFLICT[1:0]:   conf_cnt  <= sat_inc(conf_cnt);
          default:              integ_cnt <= sat_inc(integ_cnt);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (gated) begin
        stat_code <= ST_GATED;
      end else if (routed) begin
        stat_code <= ST_ROUTED;
      end else begin
        stat_code <= ST_INVALID;
      end
    end
  end

  // Divider operand selection: coherence first, then prediction error.
  assign sel_mean = cmd.setup_c ? coh_mean : err_mean;
  assign sel_x    = cmd.setup_c ? coh_r : perr_r;

  // Restoring division of |x - mean| by the routed total, one bit a cycle.
  assign rem_sh = {rem, dvd[div_cnt]};
  assign q_bit  = (rem_sh >= {1'b0, total});

  always_ff @(posedge clk) begin
    if (cmd.setup_c) begin
      total <= TOT_W'(upd_cnt) + TOT_W'(pred_cnt) + TOT_W'(conf_cnt) + TOT_W'(integ_cnt);
    end
    if (cmd.setup_c || cmd.setup_e) begin
      x_ge_m  <= (sel_x >= sel_mean);
      dvd     <= (sel_x >= sel_mean) ? sel_x - sel_mean : sel_mean - sel_x;
      rem     <= '0;
      quo     <= '0;
      div_cnt <= DIV_CNT_W'(VAL_W - 1);
    end else if (cmd.div_step) begin
      rem     <= q_bit ? TOT_W'(rem_sh - {1'b0, total}) : rem_sh[TOT_W-1:0];
      quo     <= {quo[VAL_W-2:0], q_bit};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // Mean update: a step up truncates, a step down rounds its magnitude up,
  // so the new mean is always the floor of the exact mean.
  assign fix_mean = cmd.fix_c ? coh_mean : err_mean;
  assign fix_val  = x_ge_m ? fix_mean + quo
                           : fix_mean - quo - VAL_W'(rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      coh_mean <= '0;
      err_mean <= '0;
    end else begin
      if (cmd.fix_c) coh_mean <= fix_val;
      if (cmd.fix_e) err_mean <= fix_val;
    end
  end

  // Output register; a new result loads when the slot is empty or drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status            <= stat_code;
      update_count      <= upd_cnt;
      prediction_count  <= pred_cnt;
      conflict_count    <= conf_cnt;
      integration_count <= integ_cnt;
      gated_count       <= gate_cnt;
      mean_coherence    <= coh_mean;
      mean_pred_error   <= err_mean;
    end
  end

  // Status back to the controller.
  assign stat.routed   = routed;
  assign stat.div_done = (div_cnt == '0);
  assign stat.out_free = !res_valid || !res_stall;

endmodule

// ===== rtl/urgency_gate_signal_stats.sv =====
// ============================================================================
// urgency_gate_signal_stats
// Urgency-gated signal router statistics: top level.
// ============================================================================
// Usage:
//   Input channel (sig_valid / sig_stall) carries one signal item: kind,
//   urgency, coherence and pred_error. Result channel (res_valid /
//   res_stall) returns one item per input: status plus a snapshot of all
//   counters and both running means after that item.
//   The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   is always ready; write it only while no item is in flight.
// Sequencing:
//   A gated or rejected item passes the scale, boost and decide states and
//   then loads its result from the done state. A routed item also runs two
//   17-step divisions of the mean difference by the routed total, one after
//   the other on a single shared divider, before the done state. The
//   controller returns to idle at the edge that loads the result.
//   One item is in the block at a time; sig_stall is low only while the
//   controller is idle.
// Reset:
//   Synchronous, active high: counters and means clear, registers take
//   their defaults, and no result is pending.
// Stall:
//   The result register holds while res_stall is high; a finished item
//   waits in the controller until the register frees, and the next item
//   can be accepted while the last result is still waiting.
// ============================================================================
module urgency_gate_signal_stats (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [usgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usgs_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           sig_valid,
  output logic                           sig_stall,
  input  logic [2:0]                     kind,
  input  logic [usgs_pkg::VAL_W-1:0]     urgency,
  input  logic [usgs_pkg::VAL_W-1:0]     coherence,
  input  logic [usgs_pkg::VAL_W-1:0]     pred_error,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [1:0]                     status,
  output logic [usgs_pkg::CNT_W-1:0]     update_count,
  output logic [usgs_pkg::CNT_W-1:0]     prediction_count,
  output logic [usgs_pkg::CNT_W-1:0]     conflict_count,
  output logic [usgs_pkg::CNT_W-1:0]     integration_count,
  output logic [usgs_pkg::CNT_W-1:0]     gated_count,
  output logic [usgs_pkg::VAL_W-1:0]     mean_coherence,
  output logic [usgs_pkg::VAL_W-1:0]     mean_pred_error
);
  import usgs_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  // Controller.
  usgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sig_valid (sig_valid),
    .sig_stall (sig_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  usgs_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .kind              (kind),
    .urgency           (urgency),
    .coherence         (coherence),
    .pred_error        (pred_error),
    .cmd               (cmd),
    .stat              (stat),
    .res_stall         (res_stall),
    .res_valid         (res_valid),
    .status            (status),
    .update_count      (update_count),
    .prediction_count  (prediction_count),
    .conflict_count    (conflict_count),
    .integration_count (integration_count),
    .gated_count       (gated_count),
    .mean_coherence    (mean_coherence),
    .mean_pred_error   (mean_pred_error)
  );

endmodule

// ===== rtl/usgs_checker.sv =====
// ============================================================================
// usgs_checker
// Port-level checks for the urgency gate signal statistics block.
// ============================================================================
module usgs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       sig_valid,
  input logic                       sig_stall,
  input logic                       res_valid,
  input logic                       res_stall,
  input logic [1:0]                 status,
  input logic [usgs_pkg::VAL_W-1:0] mean_coherence,
  input logic [usgs_pkg::VAL_W-1:0] mean_pred_error
);
  import usgs_pkg::*;

  // A waiting result stays valid until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // One item at a time: the input stalls right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sig_valid && !sig_stall |=> sig_stall)
    else $error("input not stalled after accepting an item");

  // No result is valid in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // Status codes and means stay in range.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status != 2'd3) && (mean_coherence <= ONE)
                  && (mean_pred_error <= ONE))
    else $error("result field out of range");

endmodule

bind urgency_gate_signal_stats usgs_checker u_usgs_checker (
  .clk             (clk),
  .rst             (rst),
  .sig_valid       (sig_valid),
  .sig_stall       (sig_stall),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .status          (status),
  .mean_coherence  (mean_coherence),
  .mean_pred_error (mean_pred_error)
);

// ===== tb/urgency_gate_signal_stats_tb.sv =====
// ============================================================================
// urgency_gate_signal_stats_tb
// Self-checking testbench for the urgency gate signal statistics block.
// ============================================================================
// A directed table covers the state after reset, field extremes, every signal
// kind, the gate boundary for plain and boosted conflict signals, invalid
// kinds on both sides of the gate, gating switched off and a threshold above
// one. Random phases follow, each under its own register settings; all but
// every third have idle gaps on the signal side and stalls on the result side.
// Results are compared field by field with written-out values for the first
// rows, else with a predictor keeping copies of counters, means and registers.
// ============================================================================
module urgency_gate_signal_stats_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usgs_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 60;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_PHASES   = 14;
  localparam int SCRIPTED_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 120;

  // Kinds past integration are rejected unless the gate catches them first.
  localparam logic [2:0] KIND_BAD_FIRST = 3'd4;
  localparam logic [2:0] KIND_BAD_LAST  = 3'd7;

  // Register indexes with no register behind them.
  localparam int CFG_SPARE_FIRST = 5;
  localparam int CFG_SPARE_LAST  = 7;

  localparam logic [VAL_W-1:0] VAL_ALL = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Snapshot carried by one result item.
  typedef struct {
    status_t          st;
    logic [CNT_W-1:0] upd, pred, confl, integ, gated;
    logic [VAL_W-1:0] coh, err;
  } stats_snapshot_t;

  // One row of stimulus: either a register write or a signal item.
  typedef struct {
    bit                   is_write;
    cfg_idx_t             reg_idx;
    logic [CFG_DAT_W-1:0] reg_data;
    logic [2:0]           kind;
    logic [VAL_W-1:0]     urg, coh, err;
    bit                   typed;
    stats_snapshot_t      want;
  } signal_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 sig_valid = 1'b0;
  logic                 sig_stall;
  logic [2:0]           kind       = '0;
  logic [VAL_W-1:0]     urgency    = '0;
  logic [VAL_W-1:0]     coherence  = '0;
  logic [VAL_W-1:0]     pred_error = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [1:0]           status;
  logic [CNT_W-1:0]     update_count;
  logic [CNT_W-1:0]     prediction_count;
  logic [CNT_W-1:0]     conflict_count;
  logic [CNT_W-1:0]     integration_count;
  logic [CNT_W-1:0]     gated_count;
  logic [VAL_W-1:0]     mean_coherence;
  logic [VAL_W-1:0]     mean_pred_error;

  // Predictor copy of the registers and the statistics.
  bit                  gate_on;
  bit                  boost_on;
  logic [VAL_W-1:0]    thr_q;
  logic [BOOST_W-1:0]  boost_q;
  logic [VAL_W-1:0]    att_q;
  logic [CNT_W-1:0]    kind_cnt [4];
  logic [CNT_W-1:0]    gated_cnt;
  logic [VAL_W-1:0]    coh_mean;
  logic [VAL_W-1:0]    err_mean;

  stats_snapshot_t pending_stats[$];
  int error_count = 0;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  urgency_gate_signal_stats i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sig_valid         (sig_valid),
    .sig_stall         (sig_stall),
    .kind              (kind),
    .urgency           (urgency),
    .coherence         (coherence),
    .pred_error        (pred_error),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .status            (status),
    .update_count      (update_count),
    .prediction_count  (prediction_count),
    .conflict_count    (conflict_count),
    .integration_count (integration_count),
    .gated_count       (gated_count),
    .mean_coherence    (mean_coherence),
    .mean_pred_error   (mean_pred_error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void stats_reset();
    gate_on   = 1'b1;
    boost_on  = 1'b1;
    thr_q     = THRESHOLD_RST;
    boost_q   = BOOST_RST;
    att_q     = ONE;
    foreach (kind_cnt[i]) kind_cnt[i] = '0;
    gated_cnt = '0;
    coh_mean  = '0;
    err_mean  = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_GATING_EN:   gate_on  = data[0];
      CFG_CONFLICT_EN: boost_on = data[0];
      CFG_THRESHOLD:   thr_q    = data[VAL_W-1:0];
      CFG_BOOST:       boost_q  = data[BOOST_W-1:0];
      CFG_ATTENTION:   att_q    = data[VAL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] sat_one(logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == CNT_SAT) ? c : c + 1'b1;
  endfunction

  // Floor of (m * (total - 1) + x) / total, taken as a step from the old mean
  // so nothing overflows. A step down rounds its magnitude up.
  function automatic logic [VAL_W-1:0] running_mean(logic [VAL_W-1:0] m, logic [VAL_W-1:0] x,
                                                    longint unsigned total);
    longint unsigned mm;
    longint unsigned xx;
    mm = 64'(m);
    xx = 64'(x);
    if (xx >= mm) return VAL_W'(mm + (xx - mm) / total);
    return VAL_W'(mm - (mm - xx + total - 1) / total);
  endfunction

  function automatic stats_snapshot_t route_signal(logic [2:0] k, logic [VAL_W-1:0] urg,
                                                   logic [VAL_W-1:0] coh, logic [VAL_W-1:0] err);
    logic [VAL_W-1:0] u;
    longint unsigned  eff;
    longint unsigned  total;
    bit               gated;
    stats_snapshot_t  r;
    u     = sat_one(urg);
    gated = 1'b0;
    // The gate is tested before the kind, so invalid kinds can be gated too.
    if (gate_on) begin
      eff = (64'(u) * 64'(sat_one(att_q))) >> FRAC_BITS;
      if (boost_on && k == KIND_CONFLICT) begin
        eff = (eff * 64'(boost_q)) >> BOOST_FRAC;
        if (eff > 64'(ONE)) eff = 64'(ONE);
      end
      gated = (eff < 64'(thr_q));
    end
    if (gated) begin
      gated_cnt = bump(gated_cnt);
      r.st      = ST_GATED;
    end else if (k >= KIND_BAD_FIRST) begin
      r.st = ST_INVALID;
    end else begin
      kind_cnt[k] = bump(kind_cnt[k]);
      total = 64'(kind_cnt[KIND_UPDATE]) + 64'(kind_cnt[KIND_PREDICTION]) +
              64'(kind_cnt[KIND_CONFLICT]) + 64'(kind_cnt[KIND_INTEGRATION]);
      coh_mean = running_mean(coh_mean, sat_one(coh), total);
      err_mean = running_mean(err_mean, sat_one(err), total);
      r.st     = ST_ROUTED;
    end
    r.upd   = kind_cnt[KIND_UPDATE];
    r.pred  = kind_cnt[KIND_PREDICTION];
    r.confl = kind_cnt[KIND_CONFLICT];
    r.integ = kind_cnt[KIND_INTEGRATION];
    r.gated = gated_cnt;
    r.coh   = coh_mean;
    r.err   = err_mean;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Most idle stretches are short, a few are long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic signal_row_t sig_row(logic [2:0] k, logic [VAL_W-1:0] urg,
                                          logic [VAL_W-1:0] coh, logic [VAL_W-1:0] err);
    signal_row_t r;
    r.is_write = 1'b0;
    r.typed    = 1'b0;
    r.kind     = k;
    r.urg      = urg;
    r.coh      = coh;
    r.err      = err;
    return r;
  endfunction

  function automatic signal_row_t reg_row(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    signal_row_t r;
    r.is_write = 1'b1;
    r.typed    = 1'b0;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic signal_row_t typed_row(logic [2:0] k, logic [VAL_W-1:0] urg,
      logic [VAL_W-1:0] coh, logic [VAL_W-1:0] err, status_t st,
      logic [CNT_W-1:0] upd, logic [CNT_W-1:0] pred, logic [CNT_W-1:0] confl,
      logic [CNT_W-1:0] integ, logic [CNT_W-1:0] gated,
      logic [VAL_W-1:0] mc, logic [VAL_W-1:0] me);
    signal_row_t r;
    r            = sig_row(k, urg, coh, err);
    r.typed      = 1'b1;
    r.want.st    = st;
    r.want.upd   = upd;
    r.want.pred  = pred;
    r.want.confl = confl;
    r.want.integ = integ;
    r.want.gated = gated;
    r.want.coh   = mc;
    r.want.err   = me;
    return r;
  endfunction

  // Urgency close to the value that lands the effective urgency on the
  // threshold under the current attention and boost.
  function automatic logic [VAL_W-1:0] urgency_near_gate(logic [2:0] k);
    longint unsigned  target;
    logic [VAL_W-1:0] a;
    a      = sat_one(att_q);
    target = 64'(thr_q);
    if (a != '0) target = (target << FRAC_BITS) / 64'(a);
    if (boost_on && k == KIND_CONFLICT && boost_q != '0)
      target = (target << BOOST_FRAC) / 64'(boost_q);
    target = target + $urandom_range(8);
    target = (target > 4) ? target - 4 : 0;
    if (target > 64'(VAL_ALL)) target = 64'(VAL_ALL);
    return VAL_W'(target);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    if ($urandom_range(4) == 0) return VAL_W'($urandom);
    return VAL_W'($urandom_range(ONE));
  endfunction

  function automatic signal_row_t random_signal();
    signal_row_t r;
    int          pick;
    logic [2:0]  k;
    if ($urandom_range(6) == 0) k = 3'($urandom_range(KIND_BAD_LAST, KIND_BAD_FIRST));
    else k = 3'($urandom_range(KIND_INTEGRATION, KIND_UPDATE));
    r    = sig_row(k, '0, random_value(), random_value());
    pick = $urandom_range(9);
    if (pick < 2) r.urg = VAL_W'($urandom);
    else if (pick < 5) r.urg = urgency_near_gate(k);
    else r.urg = VAL_W'($urandom_range(ONE));
    return r;
  endfunction

  // Offers one signal item and records its expected result on acceptance.
  task automatic send_signal(signal_row_t row);
    int              gap;
    stats_snapshot_t predicted;
    gap = pick_gap(gap_pct);
    if (gap != 0) begin
      sig_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sig_valid  <= 1'b1;
    kind       <= row.kind;
    urgency    <= row.urg;
    coherence  <= row.coh;
    pred_error <= row.err;
    do @(posedge clk); while (sig_stall !== 1'b0);
    predicted = route_signal(row.kind, row.urg, row.coh, row.err);
    pending_stats.push_back(row.typed ? row.want : predicted);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic wait_idle();
    sig_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a full register set, preceded by a write to an unused index.
  task automatic set_config(bit g, bit cp, logic [VAL_W-1:0] thr,
                            logic [CFG_DAT_W-1:0] boost, logic [VAL_W-1:0] att);
    wait_idle();
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
              CFG_DAT_W'($urandom));
    write_reg(CFG_GATING_EN, {(CFG_DAT_W-1)'($urandom), g});
    write_reg(CFG_CONFLICT_EN, {(CFG_DAT_W-1)'($urandom), cp});
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_BOOST, boost);
    write_reg(CFG_ATTENTION, att);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, checking, run limit
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_backpressure
    int run;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      run = pick_gap(stall_pct);
      res_stall  <= (run != 0);
      stall_left <= run;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    stats_snapshot_t want;
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("result item with none pending, status %0d", status));
      end else begin
        want = pending_stats.pop_front();
        check_field("status", status, want.st);
        check_field("update_count", update_count, want.upd);
        check_field("prediction_count", prediction_count, want.pred);
        check_field("conflict_count", conflict_count, want.confl);
        check_field("integration_count", integration_count, want.integ);
        check_field("gated_count", gated_count, want.gated);
        check_field("mean_coherence", mean_coherence, want.coh);
        check_field("mean_pred_error", mean_pred_error, want.err);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    signal_row_t rows[$];
    stats_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The first rows start from reset with default registers,
    // so their results are written out in full.
    rows.push_back(typed_row(KIND_UPDATE, ONE, ONE, '0,
                             ST_ROUTED, 1, 0, 0, 0, 0, ONE, '0));
    rows.push_back(typed_row(KIND_PREDICTION, '0, '0, ONE,
                             ST_GATED, 1, 0, 0, 0, 1, ONE, '0));
    rows.push_back(typed_row(KIND_BAD_LAST, VAL_ALL, VAL_ALL, VAL_ALL,
                             ST_INVALID, 1, 0, 0, 0, 1, ONE, '0));
    rows.push_back(typed_row(KIND_PREDICTION, VAL_ALL, VAL_ALL, VAL_ALL,
                             ST_ROUTED, 1, 1, 0, 0, 1, ONE, ONE >> 1));
    // Boosted conflict exactly at the threshold, then one step below it.
    rows.push_back(sig_row(KIND_CONFLICT, VAL_W'(8738), '0, '0));
    rows.push_back(sig_row(KIND_CONFLICT, VAL_W'(8737), ONE, ONE));
    // Plain urgency at the threshold and one below.
    rows.push_back(sig_row(KIND_INTEGRATION, THRESHOLD_RST, VAL_W'(12345), ONE));
    rows.push_back(sig_row(KIND_UPDATE, THRESHOLD_RST - 1'b1, ONE, ONE));
    // Invalid kinds: caught by the gate, and past it.
    rows.push_back(sig_row(KIND_BAD_FIRST, '0, ONE, ONE));
    rows.push_back(sig_row(KIND_BAD_FIRST + 3'd1, THRESHOLD_RST, ONE, ONE));
    rows.push_back(sig_row(KIND_BAD_FIRST + 3'd2, VAL_W'(17'h10001), '0, '0));
    // Boost capped at one, and inputs above one.
    rows.push_back(sig_row(KIND_CONFLICT, ONE, ONE, ONE));
    rows.push_back(sig_row(KIND_CONFLICT, VAL_ALL, VAL_ALL, '0));
    rows.push_back(sig_row(KIND_PREDICTION, ONE - 1'b1, ONE - 1'b1, ONE - 1'b1));
    rows.push_back(sig_row(KIND_UPDATE, VAL_W'(17'h10001), VAL_W'(1), VAL_W'(17'h1FFFE)));
    rows.push_back(sig_row(KIND_INTEGRATION, '0, '0, '0));
    // Gating off: nothing is gated and invalid kinds are always rejected.
    rows.push_back(reg_row(CFG_GATING_EN, CFG_DAT_W'(0)));
    rows.push_back(sig_row(KIND_UPDATE, '0, ONE, '0));
    rows.push_back(sig_row(KIND_BAD_LAST, '0, '0, '0));
    // Threshold above one gates everything.
    rows.push_back(reg_row(CFG_GATING_EN, CFG_DAT_W'(1)));
    rows.push_back(reg_row(CFG_THRESHOLD, CFG_DAT_W'(VAL_ALL)));
    rows.push_back(sig_row(KIND_UPDATE, ONE, ONE, ONE));
    rows.push_back(reg_row(CFG_THRESHOLD, CFG_DAT_W'(THRESHOLD_RST)));

    gap_pct   = 30;
    stall_pct = 30;
    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].is_write) begin
        if (i == 0 || !rows[i-1].is_write) wait_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_data);
        if (i + 1 == rows.size() || !rows[i+1].is_write) cfg_valid <= 1'b0;
      end else begin
        send_signal(rows[i]);
      end
    end

    // Random phases: register extremes first, then random settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_config(1'b1, 1'b1, THRESHOLD_RST, CFG_DAT_W'(BOOST_RST), ONE);
        1: set_config(1'b1, 1'b1, '0, '0, ONE);
        2: set_config(1'b1, 1'b1, ONE, CFG_DAT_W'(16'hFFFF), ONE);
        3: set_config(1'b1, 1'b0, VAL_ALL, CFG_DAT_W'(BOOST_RST), ONE);
        4: set_config(1'b0, 1'b1, VAL_ALL, CFG_DAT_W'(BOOST_RST), '0);
        5: set_config(1'b1, 1'b1, THRESHOLD_RST, CFG_DAT_W'(17'h10200), '0);
        6: set_config(1'b1, 1'b1, ONE / 10, CFG_DAT_W'(BOOST_RST), VAL_ALL);
        default: set_config($urandom_range(3) != 0, 1'($urandom_range(1)),
                            ($urandom_range(7) == 0) ? VAL_W'($urandom)
                                                     : VAL_W'($urandom_range(ONE / 2)),
                            CFG_DAT_W'($urandom),
                            ($urandom_range(3) == 0) ? VAL_W'($urandom)
                                                     : VAL_W'($urandom_range(ONE, ONE / 2)));
      endcase
      // Every third phase runs with no idling on either side.
      if (phase % 3 == 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(60, 10);
        stall_pct = $urandom_range(60, 10);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_signal(random_signal());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== urgency_gate_signal_stats.f =====
rtl/usgs_pkg.sv
rtl/usgs_ctrl.sv
rtl/usgs_datapath.sv
rtl/urgency_gate_signal_stats.sv
rtl/usgs_checker.sv
tb/urgency_gate_signal_stats_tb.sv
